// File: hdl/asq_pkg.sv
// ----------------------------------------------------------------------------
// asq_pkg
// Types and constants shared by the attitude sample qualifier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asq_pkg;

   typedef enum logic [1:0] {
      STATUS_NONE        = 2'd0,
      STATUS_OK          = 2'd1,
      STATUS_IMPLAUSIBLE = 2'd2,
      STATUS_BUS_ERROR   = 2'd3
   } status_type;

   localparam logic [0:0] KIND_SERVICE    = 1'b0;
   localparam logic [0:0] KIND_INVALIDATE = 1'b1;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELTA     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FAILURES  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALE_AFTER   = 8'd3;

   localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd10;
   localparam logic [10:0] MAX_DELTA_RESET     = 11'd300;
   localparam logic [7:0]  MAX_FAILURES_RESET  = 8'd3;
   localparam logic [15:0] STALE_AFTER_RESET   = 16'd100;

   localparam logic [7:0] FAIL_COUNT_MAX = 8'd255;

   localparam logic signed [27:0] ANGLE_SCALE = 28'sd1800;
   localparam logic signed [27:0] RAW_ROUND   = 28'sd32767;
   localparam int                 RAW_SHIFT   = 15;
   localparam logic signed [12:0] HALF_TURN   = 13'sd1800;
   localparam logic signed [12:0] TURN_DDEG   = 13'sd3600;

   typedef struct packed {
      logic signed [11:0] ddeg;
      logic               delta_ok;
   } axis_result_type;

endpackage

`default_nettype wire

// File: hdl/attitude_sample_qualifier.sv
// ----------------------------------------------------------------------------
// attitude_sample_qualifier
// Throughput: one item per cycle while rsp_stall is low; the input register,
// the combinational state update and the output register form a two-stage
// pipeline with stall, through which each request item passes in order.
// Reset: synchronous; loads the register defaults and clears the pipeline
// valids and all qualifier state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module attitude_sample_qualifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [31:0]                          req_now_ms,
   input  logic                                 req_read_ok,
   input  logic [47:0]                          req_read_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic signed [11:0]                   rsp_roll_angle,
   output logic signed [11:0]                   rsp_pitch_angle,
   output logic signed [11:0]                   rsp_yaw_angle,
   output logic                                 rsp_attitude_valid,
   output logic                                 rsp_stale,
   output logic                                 rsp_link_up,
   output logic                                 rsp_recover_request,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [asq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [asq_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import asq_pkg::*;

   // Configuration registers.
   logic [15:0] period_ff;
   logic [10:0] max_delta_ff;
   logic [7:0]  max_fail_ff;
   logic [15:0] stale_after_ff;

   // Input stage.
   logic        in_valid_ff, in_valid_in;
   logic        kind_ff;
   logic [31:0] now_ff;
   logic        read_ok_ff;
   logic [47:0] data_ff;

   // Qualifier state.
   logic [31:0]        next_time_ff, next_time_in;
   logic [7:0]         fail_ff, fail_in;
   logic signed [11:0] roll_ff, roll_in;
   logic signed [11:0] pitch_ff, pitch_in;
   logic signed [11:0] yaw_ff, yaw_in;
   logic               att_valid_ff, att_valid_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic               link_ff, link_in;

   // Output stage.
   logic               out_valid_ff, out_valid_in;
   status_type         status_ff, status_in;
   logic               stale_ff, stale_in;
   logic               recover_ff, recover_in;
   logic signed [11:0] out_roll_ff, out_pitch_ff, out_yaw_ff;
   logic               out_att_valid_ff, out_link_ff;

   logic            advance;
   logic            accept;
   logic            take;
   logic            due;
   logic            plausible;
   logic [7:0]      fail_bumped;
   logic [31:0]     lead;
   logic [31:0]     elapsed;
   axis_result_type roll_res, pitch_res, yaw_res;

   asq_axis u_roll (
      .raw_word (data_ff[15:0]),
      .stored   (roll_ff),
      .max_delta(max_delta_ff),
      .result   (roll_res)
   );

   asq_axis u_pitch (
      .raw_word (data_ff[31:16]),
      .stored   (pitch_ff),
      .max_delta(max_delta_ff),
      .result   (pitch_res)
   );

   asq_axis u_yaw (
      .raw_word (data_ff[47:32]),
      .stored   (yaw_ff),
      .max_delta(max_delta_ff),
      .result   (yaw_res)
   );

   assign take      = out_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (take ? 1'b0 : out_valid_ff);
   end

   always_comb begin
      next_time_in = next_time_ff;
      fail_in      = fail_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      att_valid_in = att_valid_ff;
      last_time_in = last_time_ff;
      link_in      = link_ff;
      status_in    = STATUS_NONE;
      recover_in   = 1'b0;

      // The sample is due once the wrapped time difference is not negative.
      lead        = now_ff - next_time_ff;
      due         = !lead[31];
      fail_bumped = (fail_ff == FAIL_COUNT_MAX) ? fail_ff : fail_ff + 8'd1;
      plausible   = !att_valid_ff ||
                    (roll_res.delta_ok && pitch_res.delta_ok && yaw_res.delta_ok);

      if (kind_ff == KIND_INVALIDATE) begin
         att_valid_in = 1'b0;
      end else if (due) begin
         next_time_in = now_ff + 32'(period_ff);
         if (!read_ok_ff) begin
            fail_in      = fail_bumped;
            link_in      = 1'b0;
            att_valid_in = 1'b0;
            recover_in   = (fail_bumped >= max_fail_ff);
            status_in    = STATUS_BUS_ERROR;
         end else if (!plausible) begin
            fail_in      = fail_bumped;
            att_valid_in = 1'b0;
            status_in    = STATUS_IMPLAUSIBLE;
         end else begin
            roll_in      = roll_res.ddeg;
            pitch_in     = pitch_res.ddeg;
            yaw_in       = yaw_res.ddeg;
            att_valid_in = 1'b1;
            last_time_in = now_ff;
            fail_in      = 8'd0;
            link_in      = 1'b1;
            status_in    = STATUS_OK;
         end
      end

      elapsed  = now_ff - last_time_in;
      stale_in = !att_valid_in || (elapsed >= 32'(stale_after_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= SAMPLE_PERIOD_RESET;
         max_delta_ff   <= MAX_DELTA_RESET;
         max_fail_ff    <= MAX_FAILURES_RESET;
         stale_after_ff <= STALE_AFTER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: begin
               period_ff <= csr_wdata;
            end
            CSR_MAX_DELTA: begin
               max_delta_ff <= csr_wdata[10:0];
            end
            CSR_MAX_FAILURES: begin
               max_fail_ff <= csr_wdata[7:0];
            end
            CSR_STALE_AFTER: begin
               stale_after_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         next_time_ff <= '0;
         fail_ff      <= '0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         att_valid_ff <= 1'b0;
         last_time_ff <= '0;
         link_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            next_time_ff <= next_time_in;
            fail_ff      <= fail_in;
            roll_ff      <= roll_in;
            pitch_ff     <= pitch_in;
            yaw_ff       <= yaw_in;
            att_valid_ff <= att_valid_in;
            last_time_ff <= last_time_in;
            link_ff      <= link_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind;
         now_ff     <= req_now_ms;
         read_ok_ff <= req_read_ok;
         data_ff    <= req_read_data;
      end
      if (advance) begin
         status_ff        <= status_in;
         stale_ff         <= stale_in;
         recover_ff       <= recover_in;
         out_roll_ff      <= roll_in;
         out_pitch_ff     <= pitch_in;
         out_yaw_ff       <= yaw_in;
         out_att_valid_ff <= att_valid_in;
         out_link_ff      <= link_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_roll_angle      = out_roll_ff;
   assign rsp_pitch_angle     = out_pitch_ff;
   assign rsp_yaw_angle       = out_yaw_ff;
   assign rsp_attitude_valid  = out_att_valid_ff;
   assign rsp_stale           = stale_ff;
   assign rsp_link_up         = out_link_ff;
   assign rsp_recover_request = recover_ff;

endmodule

`default_nettype wire

// File: hdl/asq_axis.sv
// ----------------------------------------------------------------------------
// asq_axis
// Converts one raw angle word to decidegrees and checks the wrapped change
// against the stored angle of the same axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asq_axis (
   input  logic [15:0]             raw_word,
   input  logic signed [11:0]      stored,
   input  logic [10:0]             max_delta,
   output asq_pkg::axis_result_type result
);
   import asq_pkg::*;

   logic signed [27:0] product;
   logic signed [27:0] biased;
   logic signed [27:0] quotient;
   logic signed [12:0] fresh_ext;
   logic signed [12:0] diff;
   logic signed [12:0] wrapped;
   logic signed [12:0] limit;

   always_comb begin
      product  = 28'(signed'(raw_word)) * ANGLE_SCALE;
      // Bias negative products so that the shift rounds toward zero.
      biased   = product + ((product < 0) ? RAW_ROUND : 28'sd0);
      quotient = biased >>> RAW_SHIFT;
      fresh_ext = quotient[12:0];
      diff     = fresh_ext - 13'(stored);
      if (diff > HALF_TURN) begin
         wrapped = diff - TURN_DDEG;
      end else if (diff < -HALF_TURN) begin
         wrapped = diff + TURN_DDEG;
      end else begin
         wrapped = diff;
      end
      limit = signed'({2'b00, max_delta});
      result.ddeg     = quotient[11:0];
      result.delta_ok = (wrapped >= -limit) && (wrapped <= limit);
   end

endmodule

`default_nettype wire

// File: hdl/asq_checker.sv
// ----------------------------------------------------------------------------
// asq_checker
// Port-level checks on the response channel of the attitude sample qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_attitude_valid,
   input wire logic        rsp_stale,
   input wire logic        rsp_link_up,
   input wire logic        rsp_recover_request
);
   import asq_pkg::*;

   // A stalled response item must stay valid with status and recovery unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_recover_request))
      else $error("stalled response item changed");

   a_recover_only_on_bus_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_recover_request |-> rsp_status == STATUS_BUS_ERROR)
      else $error("recovery requested without a bus read error");

   a_ok_sets_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_attitude_valid && rsp_link_up)
      else $error("good sample without valid attitude and link");

   a_bus_error_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BUS_ERROR |-> !rsp_attitude_valid && !rsp_link_up)
      else $error("bus read error left attitude valid or link up");

   a_invalid_is_stale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_attitude_valid |-> rsp_stale)
      else $error("invalid attitude not reported stale");

endmodule

bind attitude_sample_qualifier asq_checker u_asq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_attitude_valid (rsp_attitude_valid),
   .rsp_stale          (rsp_stale),
   .rsp_link_up        (rsp_link_up),
   .rsp_recover_request(rsp_recover_request)
);

`default_nettype wire
